### hdl/i2c_master_byte_engine_defines.svh
// Assertion helpers shared by the engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/i2cm_pkg.sv
package i2cm_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int CFG_ADDR_W      = 1;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_TICKS      = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ACK_SAMPLE_TICKS = 1'd1;

  localparam logic [15:0] PHASE_TICKS_RST      = 16'd2000;
  localparam logic [7:0]  ACK_SAMPLE_TICKS_RST = 8'd20;

  localparam logic [2:0] FUNC_START   = 3'd0;
  localparam logic [2:0] FUNC_STOP    = 3'd1;
  localparam logic [2:0] FUNC_WRITE   = 3'd2;
  localparam logic [2:0] FUNC_READ    = 3'd3;
  localparam logic [2:0] FUNC_RECOVER = 3'd4;

  typedef enum logic [2:0] {
    OP_IDLE    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_READ    = 3'd4,
    OP_RECOVER = 3'd5
  } op_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl;
    logic       sda_oe;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_ok;
    logic [7:0] rx_byte;
  } out_t;

endpackage

### hdl/i2c_master_byte_engine.sv
// I2C master byte engine: one bus tick per transfer on the input channel.
// The result of a tick is registered and offered in the cycle after accept.
// Throughput: one tick per cycle while the receiver takes results; the output register refills while it is taken.
// Synchronous active-low reset returns the bus engine to idle with SCL and SDA
// driven high and loads the phase and acknowledge-poll lengths with defaults.
module i2c_master_byte_engine #(
  parameter int TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  i2cm_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output i2cm_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [i2cm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import i2cm_pkg::*;
  `include "i2c_master_byte_engine_defines.svh"

  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  logic [15:0]            phase_ticks_r;
  logic [7:0]             ack_sample_ticks_r;
  op_t                    op_r, op_nxt;
  logic [2:0]             phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt;
  logic [3:0]             bit_idx_r, bit_idx_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic                   ack_flag_r, ack_flag_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_lvl_r, sda_lvl_nxt;
  logic                   sda_drv_r, sda_drv_nxt;
  logic                   answer_r, answer_nxt;
  logic [7:0]             rx_r, rx_nxt;
  logic                   out_valid_r;
  out_t                   out_r, out_nxt;

  logic                   accept;
  logic                   enter;
  logic                   done;
  logic [15:0]            len16;
  logic [CMP_W-1:0]       len_ext;
  logic [TIMER_WIDTH-1:0] timer_inc;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Length of the current phase; the acknowledge poll of a write has its own.
  always_comb begin
    len16 = (op_r == OP_WRITE && phase_r == 3'd3) ? {8'd0, ack_sample_ticks_r}
                                                  : phase_ticks_r;
    if (len16 == 16'd0) begin
      len16 = 16'd1;
    end
    len_ext = CMP_W'(len16);
    if (len_ext > CMP_W'({TIMER_WIDTH{1'b1}})) begin
      len_ext = CMP_W'({TIMER_WIDTH{1'b1}});
    end
  end

  assign timer_inc = timer_r + TIMER_WIDTH'(1);

  always_comb begin
    op_nxt       = op_r;
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;
    bit_idx_nxt  = bit_idx_r;
    shift_nxt    = shift_r;
    ack_flag_nxt = ack_flag_r;
    scl_nxt      = scl_r;
    sda_lvl_nxt  = sda_lvl_r;
    sda_drv_nxt  = sda_drv_r;
    answer_nxt   = answer_r;
    rx_nxt       = rx_r;
    enter        = 1'b0;
    done         = 1'b0;

    if (op_r == OP_IDLE) begin
      if (in_data.cmd_valid) begin
        case (in_data.func)
          FUNC_START:   op_nxt = OP_START;
          FUNC_STOP:    op_nxt = OP_STOP;
          FUNC_WRITE:   op_nxt = OP_WRITE;
          FUNC_READ:    op_nxt = OP_READ;
          FUNC_RECOVER: op_nxt = OP_RECOVER;
          default:      op_nxt = OP_IDLE;
        endcase
        if (op_nxt != OP_IDLE) begin
          timer_nxt   = '0;
          bit_idx_nxt = 4'd0;
          phase_nxt   = 3'd0;
          enter       = 1'b1;
          if (op_nxt == OP_WRITE) begin
            shift_nxt = in_data.tx_byte;
          end
          if (op_nxt == OP_READ) begin
            shift_nxt  = 8'd0;
            answer_nxt = in_data.send_ack;
          end
        end
      end
    end else begin
      if (op_r == OP_WRITE && phase_r == 3'd3 && !in_data.sda_in) begin
        ack_flag_nxt = 1'b1;
      end
      if (CMP_W'(timer_inc) >= len_ext) begin
        timer_nxt = '0;
        case (op_r)
          OP_START, OP_STOP: begin
            if (phase_r < 3'd3) begin
              phase_nxt = phase_r + 3'd1;
              enter     = 1'b1;
            end else begin
              op_nxt    = OP_IDLE;
              phase_nxt = 3'd0;
              done      = 1'b1;
            end
          end
          OP_RECOVER: begin
            if (phase_r < 3'd2) begin
              phase_nxt = phase_r + 3'd1;
              enter     = 1'b1;
            end else begin
              op_nxt    = OP_IDLE;
              phase_nxt = 3'd0;
              done      = 1'b1;
            end
          end
          OP_WRITE: begin
            if (phase_r == 3'd0) begin
              phase_nxt = 3'd1;
              enter     = 1'b1;
            end else if (phase_r == 3'd1) begin
              shift_nxt   = {shift_r[6:0], 1'b0};
              scl_nxt     = 1'b0;
              bit_idx_nxt = bit_idx_r + 4'd1;
              phase_nxt   = (bit_idx_nxt < 4'd8) ? 3'd0 : 3'd2;
              enter       = 1'b1;
            end else if (phase_r < 3'd4) begin
              phase_nxt = phase_r + 3'd1;
              enter     = 1'b1;
            end else begin
              scl_nxt     = 1'b0;
              sda_drv_nxt = 1'b1;
              sda_lvl_nxt = 1'b1;
              op_nxt      = OP_IDLE;
              phase_nxt   = 3'd0;
              done        = 1'b1;
            end
          end
          OP_READ: begin
            if (phase_r == 3'd1) begin
              shift_nxt = {shift_r[6:0], in_data.sda_in};
              scl_nxt   = 1'b0;
              phase_nxt = 3'd2;
              enter     = 1'b1;
            end else if (phase_r == 3'd2) begin
              bit_idx_nxt = bit_idx_r + 4'd1;
              phase_nxt   = (bit_idx_nxt < 4'd8) ? 3'd1 : 3'd3;
              enter       = 1'b1;
            end else if (phase_r < 3'd5) begin
              phase_nxt = phase_r + 3'd1;
              enter     = 1'b1;
            end else begin
              op_nxt    = OP_IDLE;
              phase_nxt = 3'd0;
              done      = 1'b1;
            end
          end
          default: begin
            op_nxt    = OP_IDLE;
            phase_nxt = 3'd0;
          end
        endcase
      end else begin
        timer_nxt = timer_inc;
      end
    end

    // Bus level changes that take effect as a new phase begins.
    if (enter) begin
      case (op_nxt)
        OP_START: begin
          case (phase_nxt)
            3'd0:    begin sda_drv_nxt = 1'b1; sda_lvl_nxt = 1'b1; end
            3'd1:    scl_nxt = 1'b1;
            3'd2:    begin sda_drv_nxt = 1'b1; sda_lvl_nxt = 1'b0; end
            default: scl_nxt = 1'b0;
          endcase
        end
        OP_STOP: begin
          case (phase_nxt)
            3'd0:    scl_nxt = 1'b0;
            3'd1:    begin sda_drv_nxt = 1'b1; sda_lvl_nxt = 1'b0; end
            3'd2:    scl_nxt = 1'b1;
            default: begin sda_drv_nxt = 1'b1; sda_lvl_nxt = 1'b1; end
          endcase
        end
        OP_RECOVER: begin
          case (phase_nxt)
            3'd0:    begin sda_drv_nxt = 1'b1; sda_lvl_nxt = 1'b0; end
            3'd1:    scl_nxt = 1'b1;
            default: begin sda_drv_nxt = 1'b1; sda_lvl_nxt = 1'b1; end
          endcase
        end
        OP_WRITE: begin
          case (phase_nxt)
            3'd0:    begin sda_drv_nxt = 1'b1; sda_lvl_nxt = shift_nxt[7]; end
            3'd2:    begin sda_drv_nxt = 1'b0; ack_flag_nxt = 1'b0; end
            3'd3:    scl_nxt = 1'b1;
            default: ;
          endcase
        end
        OP_READ: begin
          case (phase_nxt)
            3'd0:       sda_drv_nxt = 1'b0;
            3'd1, 3'd4: scl_nxt = 1'b1;
            3'd3: begin
              sda_drv_nxt = 1'b1;
              sda_lvl_nxt = !answer_nxt;
              rx_nxt      = shift_nxt;
            end
            3'd5:       scl_nxt = 1'b0;
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    out_nxt.scl      = scl_nxt;
    out_nxt.sda_oe   = sda_drv_nxt;
    out_nxt.sda_out  = sda_drv_nxt && sda_lvl_nxt;
    out_nxt.busy_res = (op_nxt != OP_IDLE);
    out_nxt.done_res = done;
    out_nxt.ack_ok   = ack_flag_nxt;
    out_nxt.rx_byte  = rx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r      <= PHASE_TICKS_RST;
      ack_sample_ticks_r <= ACK_SAMPLE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PHASE_TICKS:      phase_ticks_r      <= cfg_wdata;
        REG_ACK_SAMPLE_TICKS: ack_sample_ticks_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r        <= OP_IDLE;
      phase_r     <= 3'd0;
      timer_r     <= '0;
      bit_idx_r   <= 4'd0;
      shift_r     <= 8'd0;
      ack_flag_r  <= 1'b0;
      scl_r       <= 1'b1;
      sda_lvl_r   <= 1'b1;
      sda_drv_r   <= 1'b1;
      answer_r    <= 1'b0;
      rx_r        <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        op_r       <= op_nxt;
        phase_r    <= phase_nxt;
        timer_r    <= timer_nxt;
        bit_idx_r  <= bit_idx_nxt;
        shift_r    <= shift_nxt;
        ack_flag_r <= ack_flag_nxt;
        scl_r      <= scl_nxt;
        sda_lvl_r  <= sda_lvl_nxt;
        sda_drv_r  <= sda_drv_nxt;
        answer_r   <= answer_nxt;
        rx_r       <= rx_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  `AST_NOW(a_idle_clean, op_r == OP_IDLE, timer_r == '0 && phase_r == 3'd0, "idle with live timer or phase")
  `AST_NOW(a_done_not_busy, out_valid_r && out_r.done_res, !out_r.busy_res, "done while still busy")
  `AST_NOW(a_released_low, out_valid_r && !out_r.sda_oe, !out_r.sda_out, "released SDA reads high")
  `AST_NEXT(a_accept_fills, accept, out_valid_r && out_r.busy_res == (op_r != OP_IDLE), "result register not loaded")

endmodule

### dv/i2c_bus_tick_checker.sv
module i2c_bus_tick_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  i2cm_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  i2cm_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [i2cm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              fail_count,
  output int                              pending,
  output logic                            bus_idle,
  output int                              cmds_started
);
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  // Timing registers as the engine holds them.
  logic [15:0] phase_len_cfg;
  logic [7:0]  poll_len_cfg;

  // Engine state, advanced once per accepted tick.
  op_t         cur_op;
  logic [4:0]  phase_q;
  logic [15:0] tick_cnt;
  logic [3:0]  bit_cnt;
  logic [7:0]  shreg;
  logic        ack_seen;
  logic        scl_q;
  logic        sda_q;
  logic        drive_q;
  logic        answer_q;
  logic [7:0]  rx_last;

  out_t        pending_results[$];
  out_t        want;
  int          fails;
  int          starts;

  assign fail_count = fails;

  function automatic void drive_line(input logic lvl);
    drive_q = 1'b1;
    sda_q   = lvl;
  endfunction

  // Moves to a new phase and applies the level changes made as it begins.
  function automatic void enter_phase(input logic [4:0] nxt);
    phase_q = nxt;
    case (cur_op)
      OP_START: begin
        if (phase_q == 5'd0) drive_line(1'b1);
        else if (phase_q == 5'd1) scl_q = 1'b1;
        else if (phase_q == 5'd2) drive_line(1'b0);
        else scl_q = 1'b0;
      end
      OP_STOP: begin
        if (phase_q == 5'd0) scl_q = 1'b0;
        else if (phase_q == 5'd1) drive_line(1'b0);
        else if (phase_q == 5'd2) scl_q = 1'b1;
        else drive_line(1'b1);
      end
      OP_RECOVER: begin
        if (phase_q == 5'd0) drive_line(1'b0);
        else if (phase_q == 5'd1) scl_q = 1'b1;
        else drive_line(1'b1);
      end
      OP_WRITE: begin
        if (phase_q == 5'd0) drive_line(shreg[7]);
        else if (phase_q == 5'd2) begin
          drive_q  = 1'b0;
          ack_seen = 1'b0;
        end else if (phase_q == 5'd3) scl_q = 1'b1;
      end
      OP_READ: begin
        if (phase_q == 5'd0) drive_q = 1'b0;
        else if (phase_q == 5'd1 || phase_q == 5'd4) scl_q = 1'b1;
        else if (phase_q == 5'd3) begin
          drive_line(!answer_q);
          rx_last = shreg;
        end else if (phase_q == 5'd5) scl_q = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Closes the current phase; returns 1 when the command completes.
  function automatic logic finish_phase(input logic sda_now);
    logic [4:0] last;
    last = 5'd0;
    case (cur_op)
      OP_START, OP_STOP: last = 5'd3;
      OP_RECOVER: last = 5'd2;
      OP_WRITE: begin
        if (phase_q == 5'd0) begin
          enter_phase(5'd1);
          return 1'b0;
        end
        if (phase_q == 5'd1) begin
          shreg   = {shreg[6:0], 1'b0};
          scl_q   = 1'b0;
          bit_cnt = bit_cnt + 4'd1;
          enter_phase(bit_cnt < 4'd8 ? 5'd0 : 5'd2);
          return 1'b0;
        end
        if (phase_q < 5'd4) begin
          enter_phase(phase_q + 5'd1);
          return 1'b0;
        end
        scl_q = 1'b0;
        drive_line(1'b1);
        cur_op  = OP_IDLE;
        phase_q = '0;
        return 1'b1;
      end
      OP_READ: begin
        if (phase_q == 5'd1) begin
          shreg = {shreg[6:0], sda_now};
          scl_q = 1'b0;
          enter_phase(5'd2);
          return 1'b0;
        end
        if (phase_q == 5'd2) begin
          bit_cnt = bit_cnt + 4'd1;
          enter_phase(bit_cnt < 4'd8 ? 5'd1 : 5'd3);
          return 1'b0;
        end
        last = 5'd5;
      end
      default: begin
        cur_op  = OP_IDLE;
        phase_q = '0;
        return 1'b0;
      end
    endcase
    if (phase_q < last) begin
      enter_phase(phase_q + 5'd1);
      return 1'b0;
    end
    cur_op  = OP_IDLE;
    phase_q = '0;
    return 1'b1;
  endfunction

  function automatic out_t bus_tick(input in_t t);
    out_t        r;
    logic        done;
    logic [15:0] len;
    done = 1'b0;
    if (cur_op == OP_IDLE) begin
      if (t.cmd_valid && t.func <= FUNC_RECOVER) begin
        cur_op   = op_t'(t.func + 3'd1);
        tick_cnt = '0;
        bit_cnt  = '0;
        if (cur_op == OP_WRITE) shreg = t.tx_byte;
        if (cur_op == OP_READ) begin
          shreg    = '0;
          answer_q = t.send_ack;
        end
        starts++;
        enter_phase(5'd0);
      end
    end else begin
      // Acknowledge poll: any low sample while SCL is high for the acknowledge bit counts.
      if (cur_op == OP_WRITE && phase_q == 5'd3 && !t.sda_in) ack_seen = 1'b1;
      tick_cnt = tick_cnt + 16'd1;
      len = (cur_op == OP_WRITE && phase_q == 5'd3) ? {8'd0, poll_len_cfg} : phase_len_cfg;
      if (len == 16'd0) len = 16'd1;
      if (tick_cnt >= len) begin
        tick_cnt = '0;
        done = finish_phase(t.sda_in);
      end
    end
    r.scl      = scl_q;
    r.sda_oe   = drive_q;
    r.sda_out  = drive_q & sda_q;
    r.busy_res = (cur_op != OP_IDLE);
    r.done_res = done;
    r.ack_ok   = ack_seen;
    r.rx_byte  = rx_last;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      phase_len_cfg = PHASE_TICKS_RST;
      poll_len_cfg  = ACK_SAMPLE_TICKS_RST;
      cur_op   = OP_IDLE;
      phase_q  = '0;
      tick_cnt = '0;
      bit_cnt  = '0;
      shreg    = '0;
      ack_seen = 1'b0;
      scl_q    = 1'b1;
      sda_q    = 1'b1;
      drive_q  = 1'b1;
      answer_q = 1'b0;
      rx_last  = '0;
      starts   = 0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PHASE_TICKS:      phase_len_cfg = cfg_wdata;
          REG_ACK_SAMPLE_TICKS: poll_len_cfg  = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_results.push_back(bus_tick(in_data));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected");
          fails++;
        end else begin
          want = pending_results.pop_front();
          check_field("scl", 8'(want.scl), 8'(out_data.scl));
          check_field("sda_oe", 8'(want.sda_oe), 8'(out_data.sda_oe));
          check_field("sda_out", 8'(want.sda_out), 8'(out_data.sda_out));
          check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
          check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
          check_field("ack_ok", 8'(want.ack_ok), 8'(out_data.ack_ok));
          check_field("rx_byte", want.rx_byte, out_data.rx_byte);
        end
      end
    end
    bus_idle     <= (cur_op == OP_IDLE);
    pending      <= pending_results.size();
    cmds_started <= starts;
  end

endmodule

### dv/i2c_master_byte_engine_tb.sv
module i2c_master_byte_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2cm_pkg::*;

  typedef enum int {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_mode_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data;
    logic       ack;
  } bus_cmd_t;

  localparam int IN_BITS = $bits(in_t);

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_t                   in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_ready;
  logic                  out_valid;
  out_t                  out_data;

  int   fail_count;
  int   pending;
  logic bus_idle;
  int   cmds_started;

  logic idle_on    = 1'b1;
  int   stall_asks = 0;

  bus_cmd_t plan[$];

  always #1 clk = ~clk;

  i2c_master_byte_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  i2c_bus_tick_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .bus_idle     (bus_idle),
    .cmds_started (cmds_started)
  );

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  // A tick with no command; the other payload bits are noise, but for SDA when the mode fixes it.
  function automatic in_t filler_tick(input sda_mode_t m);
    logic [IN_BITS-1:0] raw;
    in_t t;
    raw = IN_BITS'($urandom);
    t = raw;
    t.cmd_valid = 1'b0;
    if (m == SDA_LOW) t.sda_in = 1'b0;
    else if (m == SDA_HIGH) t.sda_in = 1'b1;
    return t;
  endfunction

  // Returns at the edge where the tick transfer completes.
  task automatic push_tick(input in_t t);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Clocks the engine until it is idle, then waits for every result.
  task automatic settle(input sda_mode_t m);
    in_valid <= 1'b0;
    @(posedge clk);
    while (!bus_idle) push_tick(filler_tick(m));
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_timing(input logic [15:0] ticks, input logic [7:0] poll);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_PHASE_TICKS;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_addr  <= REG_ACK_SAMPLE_TICKS;
    cfg_wdata <= {8'($urandom), poll};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_cmd(input logic [2:0] f, input logic [7:0] b, input logic a,
                         input sda_mode_t m);
    in_t t;
    int  base;
    base = cmds_started;
    t = filler_tick(m);
    t.cmd_valid = 1'b1;
    t.func      = f;
    t.tx_byte   = b;
    t.send_ack  = a;
    if (f > FUNC_RECOVER) push_tick(t);
    else do push_tick(t); while (cmds_started == base);
    settle(m);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int seen;
    seen = 0;
    @(posedge clk);
    forever begin
      if (stall_asks != seen) begin
        seen = stall_asks;
        out_ready <= 1'b0;
        repeat (150) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("i2c_master_byte_engine_tb: done, errors");
    $finish;
  end

  initial begin
    in_t       t;
    sda_mode_t mode;
    int        last_started;
    int        roll;
    int        cnt;
    logic [7:0] addr;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_timing(16'd1, 8'd1);
    run_cmd(FUNC_START, 8'h00, 1'b0, SDA_RANDOM);
    run_cmd(FUNC_WRITE, 8'h00, 1'b0, SDA_LOW);
    run_cmd(FUNC_WRITE, 8'hFF, 1'b0, SDA_HIGH);
    run_cmd(FUNC_WRITE, 8'hA5, 1'b1, SDA_RANDOM);
    run_cmd(FUNC_READ, 8'h00, 1'b1, SDA_HIGH);
    run_cmd(FUNC_READ, 8'hFF, 1'b0, SDA_LOW);
    run_cmd(FUNC_READ, 8'h5A, 1'b1, SDA_RANDOM);
    run_cmd(FUNC_STOP, 8'h00, 1'b0, SDA_RANDOM);
    run_cmd(FUNC_RECOVER, 8'h00, 1'b0, SDA_RANDOM);
    // Undefined function codes leave the engine idle.
    for (int f = int'(FUNC_RECOVER) + 1; f < 8; f++) run_cmd(3'(f), 8'hC3, 1'b1, SDA_RANDOM);
    // Zero lengths behave as one tick.
    program_timing(16'd0, 8'd0);
    run_cmd(FUNC_START, 8'h00, 1'b0, SDA_RANDOM);
    run_cmd(FUNC_WRITE, 8'h96, 1'b0, SDA_RANDOM);
    run_cmd(FUNC_STOP, 8'h00, 1'b0, SDA_RANDOM);
    program_timing(16'd1, 8'd255);
    run_cmd(FUNC_WRITE, 8'h3C, 1'b0, SDA_RANDOM);
    run_cmd(FUNC_READ, 8'h00, 1'b0, SDA_RANDOM);
    // Longer phases: a recovery is the shortest command, run without gaps.
    idle_on <= 1'b0;
    program_timing(16'd40, 8'd255);
    run_cmd(FUNC_RECOVER, 8'h00, 1'b0, SDA_RANDOM);
    idle_on <= 1'b1;

    for (int p = 0; p < 6; p++) begin
      program_timing(p == 4 ? 16'd5 : 16'($urandom_range(1, 3)),
                     p == 3 ? 8'd255 : 8'($urandom_range(1, 6)));
      idle_on <= (p != 1);
      last_started = cmds_started;
      mode = SDA_RANDOM;
      for (int n = 0; n < 200; n++) begin
        if (plan.size() == 0) begin
          roll = $urandom_range(0, 9);
          if (roll < 7) begin
            // Addressed transaction: start, address, data bytes, stop.
            addr = 8'($urandom);
            cnt = $urandom_range(1, 3);
            plan.push_back(bus_cmd_t'{FUNC_START, 8'h00, 1'b0});
            plan.push_back(bus_cmd_t'{FUNC_WRITE, addr, 1'b0});
            for (int k = 0; k < cnt; k++) begin
              if (addr[0]) plan.push_back(bus_cmd_t'{FUNC_READ, 8'h00, 1'(k != cnt - 1)});
              else plan.push_back(bus_cmd_t'{FUNC_WRITE, 8'($urandom), 1'b0});
            end
            plan.push_back(bus_cmd_t'{FUNC_STOP, 8'h00, 1'b0});
          end else if (roll == 7) begin
            plan.push_back(bus_cmd_t'{FUNC_RECOVER, 8'h00, 1'b0});
          end else begin
            plan.push_back(bus_cmd_t'{3'($urandom_range(FUNC_START, FUNC_RECOVER)),
                                      8'($urandom), 1'($urandom)});
          end
        end
        t = filler_tick(mode);
        if (bus_idle) begin
          roll = $urandom_range(0, 19);
          if (roll < 17) begin
            t.cmd_valid = 1'b1;
            t.func      = plan[0].func;
            t.tx_byte   = plan[0].data;
            t.send_ack  = plan[0].ack;
          end else if (roll == 17) begin
            t.cmd_valid = 1'b1;
            t.func      = 3'($urandom_range(int'(FUNC_RECOVER) + 1, 7));
          end
        end else begin
          // Commands offered mid-operation must be ignored.
          t.cmd_valid = ($urandom_range(0, 7) == 0);
        end
        push_tick(t);
        if (cmds_started != last_started) begin
          last_started = cmds_started;
          void'(plan.pop_front());
          mode = sda_mode_t'($urandom_range(0, 2));
        end
        if (p == 2 && n == 100) stall_asks <= stall_asks + 1;
        if (p == 4 && n == 140) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      settle(mode);
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("i2c_master_byte_engine_tb: done, clean");
    else $display("i2c_master_byte_engine_tb: done, errors");
    $finish;
  end

endmodule
